[design/dasv_pkg.sv]
// ----------------------------------------------------------------------------
// dasv_pkg
// Shared types and constants of the detuned additive sawtooth voice.
// ----------------------------------------------------------------------------
package dasv_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_DETUNE  = 2'd0;
    localparam logic [1:0] CFG_CUTOFF  = 2'd1;
    localparam logic [1:0] CFG_ATTACK  = 2'd2;
    localparam logic [1:0] CFG_RELEASE = 2'd3;

    // voice state memory entries
    localparam logic [1:0] ENTRY_A     = 2'd0;
    localparam logic [1:0] ENTRY_B     = 2'd1;
    localparam logic [1:0] ENTRY_VOICE = 2'd2;
    localparam int         STATE_DEPTH = 3;
    localparam int         VOICE_W     = 39;

    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

    localparam logic [24:0] ENV_ONE    = 25'd16777216;
    localparam logic [31:0] Q30_ONE    = 32'd1073741824;
    localparam logic [31:0] INV_TWO_PI = 32'd170891319;
    localparam logic [31:0] C9         = 32'd172273;
    localparam logic [31:0] CPOLY [4]  = '{32'd5026996, 32'd85569306,
                                           32'd693598668, 32'd1686629713};

    localparam logic [31:0] FREQ_TAB [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    // divider geometry
    localparam int DIV_NW    = 48;
    localparam int DIV_DW    = 18;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = DIV_NW / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Q16.16 frequency of a note, equal temperament
    function automatic logic [29:0] note_freq(input logic [6:0] n);
        logic [3:0]  oct;
        logic [6:0]  semi;
        logic [31:0] base;
        oct = '0;
        for (int i = 1; i <= 10; i++) begin
            if (n >= 7'(12 * i)) oct = oct + 4'd1;
        end
        semi = n - 7'(oct * 12);
        base = FREQ_TAB[semi[3:0]];
        return 30'(base >> (4'd10 - oct));
    endfunction

endpackage

[design/detuned_additive_saw_voice_core.sv]
// ----------------------------------------------------------------------------
// detuned_additive_saw_voice_core
// Monophonic additive sawtooth voice, two detuned phases, linear envelope.
// ----------------------------------------------------------------------------
// a tick sums H harmonics, two sine terms per harmonic, each term through
//   the shared multiplier and the divider
// throughput: one request at a time; the next is taken while a sample waits
// reset: synchronous active low, clears config, control and memory valid bits
module detuned_additive_saw_voice_core import dasv_pkg::*; #(
    parameter int MAX_HARMONICS    = 1024,
    parameter int SAMPLE_RATE      = 44100,
    parameter int SINE_TABLE_DEPTH = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_status_byte,
    input  logic [6:0]         s_note_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [14:0]        cfg_data
);

    localparam int J_W   = $clog2(MAX_HARMONICS + 2);
    localparam int JF_W  = 30 + J_W;
    localparam int ABITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [31:0] QMASK = ~((32'd1 << (32 - ABITS)) - 32'd1);
    localparam logic [J_W-1:0] MAXJ = J_W'(MAX_HARMONICS);
    localparam logic [DIV_DW-1:0] SR = DIV_DW'(SAMPLE_RATE);

    typedef enum logic [4:0] {
        S_IDLE, S_RDV, S_RDA, S_RDB, S_HCHK, S_X, S_SQ, S_X2, S_POLY,
        S_DSTART, S_DWAIT, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6,
        S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_W0, S_W1, S_W2, S_OUT
    } state_t;

    state_t state_reg;

    logic [9:0]  detune_reg;
    logic [12:0] cutoff_reg;
    logic [14:0] attack_reg, release_reg;

    logic        action_reg;
    logic [7:0]  status_reg;
    logic [6:0]  note_reg;
    logic [24:0] env_reg;
    logic [6:0]  cur_reg, gate_reg;
    logic [31:0] base_a_reg, base_b_reg, ang_a_reg, ang_b_reg;
    logic [31:0] pa_new_reg;
    logic [29:0] freq_reg;
    logic [J_W-1:0]  j_reg;
    logic [JF_W-1:0] jf_reg;
    logic        ph_reg;
    logic [30:0] x_reg;
    logic        neg_reg;
    logic [31:0] x2_reg;
    logic [1:0]  pstep_reg;
    logic signed [37:0] acc_reg;
    logic [35:0] abs_reg;
    logic        sneg_reg;
    logic [63:0] plo_reg;
    logic [33:0] m1_reg;
    logic signed [23:0] sample_reg;
    logic [63:0] prod_reg;
    logic        m_valid_reg;
    logic signed [23:0] m_sample_reg;

    logic [2:0]  vld_reg;
    logic        rdv_reg;

    logic                ram_we, ram_re;
    logic [1:0]          ram_waddr, ram_raddr;
    logic [VOICE_W-1:0]  ram_wdata, ram_rdata, rd_word;

    logic [31:0]         mul_a, mul_b;
    logic                div_start;
    logic [DIV_NW-1:0]   div_dividend, div_q;
    logic [DIV_DW-1:0]   div_divisor;
    div_stat_t           div_stat;

    logic [31:0] cur_ang, qang, poly_t;
    logic [6:0]  ev_cur, ev_gate;
    logic [24:0] env_new;
    logic signed [37:0] qs;
    logic [63:0] m1_sum, s_sum;
    logic [31:0] smag;
    logic signed [23:0] sat_sample;

    dasv_ram #(.WIDTH(VOICE_W), .DEPTH(STATE_DEPTH)) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dasv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // entries never written read as zero
    assign rd_word = rdv_reg ? ram_rdata : '0;

    assign cur_ang = ph_reg ? ang_b_reg : ang_a_reg;
    assign qang    = cur_ang & QMASK;
    assign poly_t  = CPOLY[pstep_reg] - prod_reg[61:30];
    assign qs      = $signed({6'b0, div_q[31:0]});
    assign m1_sum  = (prod_reg << 18) + plo_reg;
    assign s_sum   = (prod_reg << 17) + plo_reg;
    assign smag    = s_sum[63:32];

    always_comb begin
        logic [31:0] sm;
        sm = smag;
        if (!sneg_reg && smag > 32'd8388607) sm = 32'd8388607;
        if (sneg_reg && smag > 32'd8388608) sm = 32'd8388608;
        sat_sample = sneg_reg ? $signed(24'(-sm)) : $signed(sm[23:0]);
    end

    // note on / note off against the stored voice word
    always_comb begin
        ev_cur  = rd_word[13:7];
        ev_gate = rd_word[6:0];
        if (status_reg[7:4] == NIB_NOTE_ON) begin
            ev_cur  = note_reg;
            ev_gate = note_reg;
        end else if (status_reg[7:4] == NIB_NOTE_OFF && note_reg == rd_word[6:0]) begin
            ev_cur  = note_reg;
            ev_gate = '0;
        end
    end

    always_comb begin
        logic signed [26:0] e;
        e = $signed({2'b0, env_reg});
        if (gate_reg != '0) begin
            if (env_reg < ENV_ONE) e = e + $signed({12'b0, attack_reg});
        end else if (env_reg != '0) begin
            e = e - $signed({12'b0, release_reg});
        end
        if (e < 0) e = '0;
        if (e > $signed({2'b0, ENV_ONE})) e = $signed({2'b0, ENV_ONE});
        env_new = e[24:0];
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = ENTRY_VOICE;
        ram_we    = 1'b0;
        ram_waddr = ENTRY_VOICE;
        ram_wdata = {rd_word[38:14], ev_cur, ev_gate};
        unique case (state_reg)
            S_IDLE: ram_re = s_valid;
            S_RDV: begin
                ram_re    = action_reg;
                ram_raddr = ENTRY_A;
                ram_we    = !action_reg;
            end
            S_RDA: begin
                ram_re    = 1'b1;
                ram_raddr = ENTRY_B;
            end
            S_W0: begin
                ram_we    = 1'b1;
                ram_waddr = ENTRY_A;
                ram_wdata = VOICE_W'(pa_new_reg);
            end
            S_W1: begin
                ram_we    = 1'b1;
                ram_waddr = ENTRY_B;
                ram_wdata = VOICE_W'(base_b_reg + div_q[31:0]);
            end
            S_W2: begin
                ram_we    = 1'b1;
                ram_wdata = {env_new, cur_reg, gate_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ: begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            S_X2: begin
                mul_a = prod_reg[61:30];
                mul_b = C9;
            end
            S_POLY: begin
                mul_a = (pstep_reg == 2'd3) ? {1'b0, x_reg} : x2_reg;
                mul_b = poly_t;
            end
            S_F1: begin
                mul_a = {14'b0, abs_reg[17:0]};
                mul_b = INV_TWO_PI;
            end
            S_F2: begin
                mul_a = {14'b0, abs_reg[35:18]};
                mul_b = INV_TWO_PI;
            end
            S_F4: begin
                mul_a = {15'b0, m1_reg[16:0]};
                mul_b = {7'b0, env_reg};
            end
            S_F5: begin
                mul_a = {15'b0, m1_reg[33:17]};
                mul_b = {7'b0, env_reg};
            end
            S_I0: begin
                mul_a = {2'b0, freq_reg};
                mul_b = 32'd65536 + {22'b0, detune_reg};
            end
            S_I3: begin
                mul_a = {2'b0, freq_reg};
                mul_b = 32'd65536 - {22'b0, detune_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start    = (state_reg == S_DSTART) || (state_reg == S_I1) || (state_reg == S_I4);
        div_dividend = prod_reg[DIV_NW-1:0];
        div_divisor  = SR;
        if (state_reg == S_DSTART) begin
            div_dividend = DIV_NW'(prod_reg[63:30]);
            div_divisor  = DIV_DW'(j_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            rdv_reg     <= 1'b0;
            detune_reg  <= '0;
            cutoff_reg  <= '0;
            attack_reg  <= '0;
            release_reg <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    CFG_DETUNE:  detune_reg  <= cfg_data[9:0];
                    CFG_CUTOFF:  cutoff_reg  <= cfg_data[12:0];
                    CFG_ATTACK:  attack_reg  <= cfg_data;
                    CFG_RELEASE: release_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ram_we) vld_reg[ram_waddr] <= 1'b1;
            if (ram_re) rdv_reg <= vld_reg[ram_raddr];
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_action;
                        status_reg <= s_status_byte;
                        note_reg   <= s_note_byte;
                        state_reg  <= S_RDV;
                    end
                end
                S_RDV: begin
                    env_reg   <= rd_word[38:14];
                    cur_reg   <= rd_word[13:7];
                    gate_reg  <= rd_word[6:0];
                    state_reg <= action_reg ? S_RDA : S_IDLE;
                end
                S_RDA: begin
                    base_a_reg <= rd_word[31:0];
                    state_reg  <= S_RDB;
                end
                S_RDB: begin
                    base_b_reg <= rd_word[31:0];
                    ang_b_reg  <= rd_word[31:0];
                    ang_a_reg  <= base_a_reg;
                    freq_reg   <= note_freq(cur_reg);
                    jf_reg     <= JF_W'(note_freq(cur_reg));
                    j_reg      <= J_W'(1);
                    ph_reg     <= 1'b0;
                    acc_reg    <= '0;
                    state_reg  <= S_HCHK;
                end
                S_HCHK: begin
                    if (j_reg <= MAXJ && jf_reg < JF_W'({cutoff_reg, 16'b0}))
                        state_reg <= S_X;
                    else
                        state_reg <= S_F0;
                end
                S_X: begin
                    // quarter-wave fold
                    x_reg     <= qang[30] ? 31'(Q30_ONE - {2'b0, qang[29:0]})
                                          : {1'b0, qang[29:0]};
                    neg_reg   <= qang[31];
                    state_reg <= S_SQ;
                end
                S_SQ: state_reg <= S_X2;
                S_X2: begin
                    x2_reg    <= prod_reg[61:30];
                    pstep_reg <= 2'd0;
                    state_reg <= S_POLY;
                end
                S_POLY: begin
                    pstep_reg <= pstep_reg + 2'd1;
                    if (pstep_reg == 2'd3) state_reg <= S_DSTART;
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (div_stat.done) begin
                        acc_reg <= neg_reg ? acc_reg - qs : acc_reg + qs;
                        if (!ph_reg) begin
                            ph_reg    <= 1'b1;
                            state_reg <= S_X;
                        end else begin
                            ph_reg    <= 1'b0;
                            j_reg     <= j_reg + 1'b1;
                            ang_a_reg <= ang_a_reg + base_a_reg;
                            ang_b_reg <= ang_b_reg + base_b_reg;
                            jf_reg    <= jf_reg + JF_W'(freq_reg);
                            state_reg <= S_HCHK;
                        end
                    end
                end
                S_F0: begin
                    sneg_reg  <= acc_reg[37];
                    abs_reg   <= acc_reg[37] ? 36'(-acc_reg) : acc_reg[35:0];
                    state_reg <= S_F1;
                end
                S_F1: state_reg <= S_F2;
                S_F2: begin
                    plo_reg   <= prod_reg;
                    state_reg <= S_F3;
                end
                S_F3: begin
                    m1_reg    <= m1_sum[63:30];
                    state_reg <= S_F4;
                end
                S_F4: state_reg <= S_F5;
                S_F5: begin
                    plo_reg   <= prod_reg;
                    state_reg <= S_F6;
                end
                S_F6: begin
                    sample_reg <= sat_sample;
                    state_reg  <= S_I0;
                end
                S_I0: state_reg <= S_I1;
                S_I1: state_reg <= S_I2;
                S_I2: begin
                    if (div_stat.done) begin
                        pa_new_reg <= base_a_reg + div_q[31:0];
                        state_reg  <= S_I3;
                    end
                end
                S_I3: state_reg <= S_I4;
                S_I4: state_reg <= S_I5;
                S_I5: if (div_stat.done) state_reg <= S_W0;
                S_W0: state_reg <= S_W1;
                S_W1: state_reg <= S_W2;
                S_W2: state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= sample_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

`ifndef SYNTH
    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_env_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_waddr == ENTRY_VOICE) |-> (ram_wdata[38:14] <= ENV_ONE))
        else $error("envelope write out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while busy");
`endif

endmodule

[design/dasv_ram.sv]
// ----------------------------------------------------------------------------
// dasv_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dasv_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 3,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        if (re) rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dasv_div.sv]
// ----------------------------------------------------------------------------
// dasv_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dasv_div import dasv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output div_stat_t         stat
);

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;

    always_comb begin
        logic [DIV_DW:0] t;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {rem_next, quo_next[DIV_NW-1]};
            quo_next = {quo_next[DIV_NW-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg}) begin
                rem_next = DIV_DW'(t - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = t[DIV_DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= DIV_CW'(DIV_STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[tb/dasv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasv_checker
// Watches the request, sample and register channels of the saw voice,
// predicts each sample from its own copy of the voice state and compares.
// ----------------------------------------------------------------------------
module dasv_checker import dasv_pkg::*; #(
    parameter int MAX_HARMONICS    = 1024,
    parameter int SAMPLE_RATE      = 44100,
    parameter int SINE_TABLE_DEPTH = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_status_byte,
    input  logic [6:0]         s_note_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [23:0] m_sample,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [14:0]        cfg_data,
    output int                 fail_count,
    output int                 samples_pending
);

    logic [9:0]  detune;
    logic [12:0] cutoff;
    logic [14:0] attack_step;
    logic [14:0] release_step;
    logic [31:0] ph_a, ph_b;
    int          env_level;
    logic [6:0]  cur_note, gate_note;
    logic signed [23:0] sample_queue[$];

    // magnitude of the sine in Q30, sign returned separately
    function automatic longint unsigned sine_mag(input logic [31:0] p, output bit neg);
        longint unsigned x, x2, t;
        x = p[29:0];
        if (p[30]) x = longint'(Q30_ONE) - x;
        x2 = (x * x) >> 30;
        t = C9;
        for (int i = 0; i < 4; i++) t = CPOLY[i] - ((x2 * t) >> 30);
        neg = p[31];
        return (x * t) >> 30;
    endfunction

    function automatic longint harmonic_sum(input logic [31:0] freq);
        longint acc;
        longint unsigned lim, k, mag;
        logic [31:0] ang, q, base;
        bit neg;
        acc = 0;
        lim = longint'(cutoff) << 16;
        for (int j = 1; j <= MAX_HARMONICS && longint'(j) * freq < lim; j++) begin
            for (int ph = 0; ph < 2; ph++) begin
                base = ph ? ph_b : ph_a;
                ang = 32'(longint'(j) * base);
                k = (longint'(ang) * SINE_TABLE_DEPTH) >> 32;
                q = 32'((k << 32) / SINE_TABLE_DEPTH);
                mag = sine_mag(q, neg) / j;
                acc = neg ? acc - longint'(mag) : acc + longint'(mag);
            end
        end
        return acc;
    endfunction

    function automatic logic signed [23:0] tick_sample();
        logic [31:0] freq;
        longint acc;
        longint unsigned mag, smag;
        bit neg;
        freq = FREQ_TAB[cur_note % 12] >> (10 - cur_note / 12);
        acc = harmonic_sum(freq);
        neg = acc < 0;
        mag = neg ? -acc : acc;
        mag = (mag * INV_TWO_PI) >> 30;
        smag = (mag * longint'(env_level)) >> 32;
        if (!neg && smag > 8388607) smag = 8388607;
        if (neg && smag > 8388608) smag = 8388608;
        ph_a = ph_a + 32'((longint'(freq) * (65536 + detune)) / SAMPLE_RATE);
        ph_b = ph_b + 32'((longint'(freq) * (65536 - detune)) / SAMPLE_RATE);
        if (gate_note != 0 && env_level < int'(ENV_ONE)) env_level += attack_step;
        if (gate_note == 0 && env_level > 0) env_level -= release_step;
        if (env_level < 0) env_level = 0;
        if (env_level > int'(ENV_ONE)) env_level = ENV_ONE;
        return neg ? -24'(smag) : 24'(smag);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            detune = '0; cutoff = '0; attack_step = '0; release_step = '0;
            ph_a = '0; ph_b = '0; env_level = 0;
            cur_note = '0; gate_note = '0;
            sample_queue.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sample_queue.size() == 0) begin
                    $error("sample %0d with no request waiting", m_sample);
                    fail_count++;
                end else begin
                    logic signed [23:0] exp_s;
                    exp_s = sample_queue.pop_front();
                    if (exp_s !== m_sample) begin
                        $error("sample: expected %0d, got %0d", exp_s, m_sample);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_DETUNE:  detune = cfg_data[9:0];
                    CFG_CUTOFF:  cutoff = cfg_data[12:0];
                    CFG_ATTACK:  attack_step = cfg_data;
                    CFG_RELEASE: release_step = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_action) begin
                    sample_queue.push_back(tick_sample());
                end else if (s_status_byte[7:4] == NIB_NOTE_ON) begin
                    cur_note = s_note_byte;
                    gate_note = s_note_byte;
                end else if (s_status_byte[7:4] == NIB_NOTE_OFF
                             && s_note_byte == gate_note) begin
                    cur_note = s_note_byte;
                    gate_note = '0;
                end
            end
        end
        samples_pending = sample_queue.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives MIDI events and sample ticks into the saw voice across several
// register settings, with random gaps and back-pressure; a checker compares.
// ----------------------------------------------------------------------------
module testbench import dasv_pkg::*;;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [7:0]         s_status_byte;
    logic [6:0]         s_note_byte;
    logic               m_valid;
    logic               m_ready;
    logic signed [23:0] m_sample;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_addr;
    logic [14:0]        cfg_data;
    int                 fail_count;
    int                 samples_pending;
    logic               hold_req;
    logic [6:0]         held_note;

    detuned_additive_saw_voice_core i_dut (.*);

    dasv_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mostly upper notes, so that ticks stay short
    function automatic logic [6:0] pick_note();
        if ($urandom_range(0, 15) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(48, 127));
    endfunction

    task automatic send_req(input logic act, input logic [7:0] st, input logic [6:0] nb);
        int g;
        s_valid = 1'b1;
        s_action = act;
        s_status_byte = st;
        s_note_byte = nb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        s_valid = 1'b0;
        @(posedge aclk);
        while (samples_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_voice(input int det, input int cut, input int att, input int rel);
        write_reg(CFG_DETUNE, 15'(det));
        write_reg(CFG_CUTOFF, 15'(cut));
        write_reg(CFG_ATTACK, 15'(att));
        write_reg(CFG_RELEASE, 15'(rel));
    endtask

    // note-on / ticks / note-off phrases with some noise mixed in
    task automatic play_random(input int n);
        int cnt;
        int r;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                send_req(1'b1, 8'($urandom), 7'($urandom));
            end else if (r < 7) begin
                held_note = pick_note();
                send_req(1'b0, {NIB_NOTE_ON, 4'($urandom)}, held_note);
            end else if (r == 7) begin
                send_req(1'b0, {NIB_NOTE_OFF, 4'($urandom)}, held_note);
            end else if (r == 8) begin
                send_req(1'b0, {NIB_NOTE_OFF, 4'($urandom)}, pick_note());
            end else begin
                send_req(1'b0, 8'($urandom), pick_note());
            end
            cnt++;
        end
    endtask

    // sample side: random stalls, plus one long hold-off on request
    initial begin
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (3000) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                burst = $urandom_range(0, 3) == 0 ? gap_len() + 1 : $urandom_range(1, 30);
                m_ready = $urandom_range(0, 3) != 0;
                repeat (burst - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        #1s;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_status_byte = '0;
        s_note_byte = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        held_note = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // widest detune, highest cutoff, fastest envelope
        set_voice(655, 5000, 16777, 16777);
        send_req(1'b1, 8'h00, 7'h00);       // tick on note zero: harmonics up to the cutoff
        send_req(1'b0, 8'h90, 7'd127);      // above cutoff: no harmonics
        send_req(1'b1, 8'hFF, 7'h7F);
        send_req(1'b1, 8'h00, 7'h00);
        send_req(1'b0, 8'h80, 7'd5);        // note-off for another note
        send_req(1'b1, 8'h55, 7'h2A);
        send_req(1'b0, 8'h8F, 7'd127);      // releases the gate
        send_req(1'b1, 8'hAA, 7'h55);
        send_req(1'b0, 8'hF0, 7'd60);       // not a note message
        send_req(1'b1, 8'h00, 7'h00);
        send_req(1'b0, 8'h9A, 7'd0);        // note-on of zero leaves gate off
        send_req(1'b1, 8'h00, 7'h00);
        send_req(1'b0, 8'h93, 7'd69);
        repeat (4) send_req(1'b1, 8'hFF, 7'h7F);
        send_req(1'b0, 8'h80, 7'd69);
        send_req(1'b1, 8'h00, 7'h00);
        send_req(1'b1, 8'h00, 7'h00);

        // all registers at zero; cheap ticks, so fill the block up
        set_voice(0, 0, 0, 0);
        hold_req = 1'b1;
        play_random(60);

        set_voice($urandom_range(1, 654), 300, 16777, 1);
        play_random(110);

        set_voice($urandom_range(0, 655), 5000, $urandom_range(0, 16777),
                  $urandom_range(0, 16777));
        play_random(100);

        s_valid = 1'b0;
        @(posedge aclk);
        while (samples_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
